// File: hw/rtl/assert_macros.svh
// Assertion helpers for the converter RTL; they compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define ITP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ITP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define ITP_ASSERT(lbl, cond, msg)
`define ITP_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

// File: hw/rtl/itp_pkg.sv
`default_nettype none

package itp_pkg;

    localparam int SYM_W  = 8;
    localparam int PREC_W = 2;

    // Operator characters
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    // Precedence levels; zero marks an operand
    localparam logic [PREC_W-1:0] PREC_NONE = 2'd0;
    localparam logic [PREC_W-1:0] PREC_ADD  = 2'd1;
    localparam logic [PREC_W-1:0] PREC_MUL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_POP_OP
    } state_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_REPLACE
    } stk_cmd_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_ABOVE,
        CELL_LOAD_BELOW
    } cell_op_t;

    typedef struct packed {
        stk_cmd_t         cmd;
        logic [SYM_W-1:0] sym;
    } stk_ctrl_t;

    function automatic logic [PREC_W-1:0] itp_prec(input logic [SYM_W-1:0] c);
        logic [PREC_W-1:0] p;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = PREC_ADD;
        end
        else if (c == CH_STAR || c == CH_SLASH) begin
            p = PREC_MUL;
        end
        else begin
            p = PREC_NONE;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itp_in_if.sv
`default_nettype none

interface itp_in_if import itp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             is_end;

    modport source (output valid, output symbol, output is_end, input ready);
    modport sink   (input valid, input symbol, input is_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/itp_out_if.sv
`default_nettype none

interface itp_out_if import itp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_symbol;
    logic             has_symbol;
    logic             last;
    logic             expr_done;
    logic             overflow;

    modport source (output valid, output out_symbol, output has_symbol, output last,
                    output expr_done, output overflow, input ready);
    modport sink   (input valid, input out_symbol, input has_symbol, input last,
                    input expr_done, input overflow, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/itp_cell.sv
`default_nettype none

module itp_cell import itp_pkg::*;
(
    input  wire logic             clk,
    input  var  cell_op_t         op,
    input  wire logic [SYM_W-1:0] from_above,
    input  wire logic [SYM_W-1:0] from_below,
    output logic      [SYM_W-1:0] data
);

    logic [SYM_W-1:0] data_reg;
    logic [SYM_W-1:0] data_next;

    // Take the neighbor's entry on a shift, otherwise hold
    always_comb
    begin
        case (op)
            CELL_LOAD_ABOVE: data_next = from_above;
            CELL_LOAD_BELOW: data_next = from_below;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/itp_stack.sv
`default_nettype none

module itp_stack import itp_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic             clk,
    input  var  stk_ctrl_t        ctrl,
    output logic      [SYM_W-1:0] top_sym,
    output logic      [SYM_W-1:0] next_sym
);

    logic [SYM_W-1:0] cell_data [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            cell_op_t         op;
            logic [SYM_W-1:0] above;
            logic [SYM_W-1:0] below;

            // Translate the stack command into this cell's shift
            always_comb
            begin
                case (ctrl.cmd)
                    STK_PUSH:    op = CELL_LOAD_ABOVE;
                    STK_POP:     op = CELL_LOAD_BELOW;
                    STK_REPLACE:
                    begin
                        if (i == 0) begin
                            op = CELL_LOAD_ABOVE;
                        end
                        else begin
                            op = CELL_HOLD;
                        end
                    end
                    default:     op = CELL_HOLD;
                endcase
            end

            if (i == 0) begin : g_head
                assign above = ctrl.sym;
            end
            else begin : g_mid
                assign above = cell_data[i-1];
            end

            if (i == DEPTH - 1) begin : g_tail
                assign below = '0;
            end
            else begin : g_inner
                assign below = cell_data[i+1];
            end

            itp_cell u_cell (
                .clk        (clk),
                .op         (op),
                .from_above (above),
                .from_below (below),
                .data       (cell_data[i])
            );
        end
    endgenerate

    assign top_sym = cell_data[0];

    // Entry that becomes the top after a pop
    generate
        if (DEPTH > 1) begin : g_next
            assign next_sym = cell_data[1];
        end
        else begin : g_no_next
            assign next_sym = '0;
        end
    endgenerate

endmodule

`default_nettype wire

// File: hw/rtl/infix_to_postfix_converter.sv
`default_nettype none
`include "assert_macros.svh"

// Infix-to-postfix converter without parentheses. One character enters per
// transfer on symbols; operands leave at once, operators wait on a stack built
// as a row of shift cells with the top at cell 0. An operator first pops the
// stacked entries of equal or higher rank and an end item flushes all of them,
// one result per cycle through the output register while results are taken;
// no new character is accepted until that is done. Each stacked operator is
// pushed and popped once. The stack holds STACK_DEPTH operators; an operator
// that pops nothing and meets a full stack is dropped and reported by a bare
// marker with overflow set. The final result of every item that yields one
// carries last, and an end item closes with a bare marker with expr_done set.
module infix_to_postfix_converter import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    itp_in_if.sink    symbols,
    itp_out_if.source results
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SYM_W-1:0]  op_sym_reg, op_sym_next;
    logic [PREC_W-1:0] op_prec_reg, op_prec_next;

    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;
    logic              out_done_reg, out_done_next;
    logic              out_ovf_reg, out_ovf_next;

    stk_ctrl_t         stk_ctrl;
    logic [SYM_W-1:0]  top_sym;
    logic [SYM_W-1:0]  next_sym;

    logic              out_free;
    logic              in_fire;
    logic [PREC_W-1:0] in_prec;
    logic              count_zero;
    logic              need_pop;
    logic              more_pops;
    logic              load_out;

    itp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk      (clk),
        .ctrl     (stk_ctrl),
        .top_sym  (top_sym),
        .next_sym (next_sym)
    );

    // Shared decode
    assign out_free      = !out_valid_reg || results.ready;
    assign symbols.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = symbols.valid && symbols.ready;
    assign in_prec       = itp_prec(symbols.symbol);
    assign count_zero    = (count_reg == '0);
    assign need_pop      = !count_zero && (itp_prec(top_sym) >= in_prec);
    assign more_pops     = (count_reg > CNT_ONE) && (itp_prec(next_sym) >= op_prec_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    if (symbols.is_end) begin
                        state_next = ST_FLUSH;
                    end
                    else if (in_prec != PREC_NONE && need_pop) begin
                        state_next = ST_POP_OP;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free && count_zero) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_OP:
            begin
                if (out_free && !more_pops) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Stack commands, results and pending operator
    always_comb
    begin
        stk_ctrl.cmd  = STK_HOLD;
        stk_ctrl.sym  = symbols.symbol;
        count_next    = count_reg;
        op_sym_next   = op_sym_reg;
        op_prec_next  = op_prec_reg;
        load_out      = 1'b0;
        out_sym_next  = '0;
        out_has_next  = 1'b0;
        out_last_next = 1'b0;
        out_done_next = 1'b0;
        out_ovf_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !symbols.is_end) begin
                    if (in_prec == PREC_NONE) begin
                        load_out      = 1'b1;
                        out_sym_next  = symbols.symbol;
                        out_has_next  = 1'b1;
                        out_last_next = 1'b1;
                    end
                    else if (need_pop) begin
                        op_sym_next  = symbols.symbol;
                        op_prec_next = in_prec;
                    end
                    else if (count_reg != CNT_FULL) begin
                        stk_ctrl.cmd = STK_PUSH;
                        count_next   = count_reg + CNT_ONE;
                    end
                    else begin
                        load_out      = 1'b1;
                        out_last_next = 1'b1;
                        out_ovf_next  = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (!count_zero) begin
                        stk_ctrl.cmd = STK_POP;
                        count_next   = count_reg - CNT_ONE;
                        out_sym_next = top_sym;
                        out_has_next = 1'b1;
                    end
                    else begin
                        out_last_next = 1'b1;
                        out_done_next = 1'b1;
                    end
                end
            end
            ST_POP_OP:
            begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_sym_next  = top_sym;
                    out_has_next  = 1'b1;
                    out_last_next = !more_pops;
                    if (more_pops) begin
                        stk_ctrl.cmd = STK_POP;
                        count_next   = count_reg - CNT_ONE;
                    end
                    else begin
                        // pop the last match and push the waiting operator at once
                        stk_ctrl.cmd = STK_REPLACE;
                        stk_ctrl.sym = op_sym_reg;
                    end
                end
            end
            default: stk_ctrl.cmd = STK_HOLD;
        endcase
    end

    // Output register: load a new result or drop the one taken
    always_comb
    begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        else if (results.ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_sym_reg  <= op_sym_next;
        op_prec_reg <= op_prec_next;
        if (load_out) begin
            out_sym_reg  <= out_sym_next;
            out_has_reg  <= out_has_next;
            out_last_reg <= out_last_next;
            out_done_reg <= out_done_next;
            out_ovf_reg  <= out_ovf_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_symbol = out_sym_reg;
    assign results.has_symbol = out_has_reg;
    assign results.last       = out_last_reg;
    assign results.expr_done  = out_done_reg;
    assign results.overflow   = out_ovf_reg;

    `ITP_ASSERT(a_count_bound, count_reg <= CNT_FULL, "stack count beyond depth")
    `ITP_ASSERT(a_ready_idle, !symbols.ready || state_reg == ST_IDLE, "ready while busy")
    `ITP_ASSERT(a_pop_nonempty, state_reg != ST_POP_OP || !count_zero, "pop on empty stack")
    `ITP_ASSERT_NEXT(a_ovf_full, load_out && out_ovf_next, count_reg == CNT_FULL, "overflow below full")
    `ITP_ASSERT_NEXT(a_done_empty, load_out && out_done_next, count_zero, "done with stacked operators")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    import itp_pkg::*;

    localparam int STACK_SLOTS = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             has_symbol;
        logic             last;
        logic             expr_done;
        logic             overflow;
    } postfix_res_t;

    // Tracks the operator stack and holds the postfix results still owed
    class postfix_scoreboard;
        logic [SYM_W-1:0] op_stack [STACK_SLOTS];
        int unsigned      stack_cnt;
        postfix_res_t     expected_postfix [$];
        int               errors;

        function new();
            stack_cnt = 0;
            errors = 0;
        endfunction

        static function logic [PREC_W-1:0] op_rank(logic [SYM_W-1:0] c);
            logic [PREC_W-1:0] r;
            case (c)
                CH_PLUS, CH_MINUS: r = PREC_ADD;
                CH_STAR, CH_SLASH: r = PREC_MUL;
                default:           r = PREC_NONE;
            endcase
            return r;
        endfunction

        function void owe(logic [SYM_W-1:0] s, logic has, logic done, logic ovf);
            postfix_res_t r;
            r.out_symbol = s;
            r.has_symbol = has;
            r.last       = 1'b0;
            r.expr_done  = done;
            r.overflow   = ovf;
            expected_postfix.push_back(r);
        endfunction

        // Predict the results of one accepted input transfer
        function void note_symbol(logic [SYM_W-1:0] s, logic is_end);
            int unsigned       first;
            logic [PREC_W-1:0] r;
            postfix_res_t      tail;
            first = expected_postfix.size();
            if (is_end) begin
                while (stack_cnt > 0) begin
                    stack_cnt--;
                    owe(op_stack[stack_cnt], 1'b1, 1'b0, 1'b0);
                end
                owe('0, 1'b0, 1'b1, 1'b0);
            end
            else begin
                r = op_rank(s);
                if (r == PREC_NONE) begin
                    owe(s, 1'b1, 1'b0, 1'b0);
                end
                else begin
                    while (stack_cnt > 0 && op_rank(op_stack[stack_cnt - 1]) >= r) begin
                        stack_cnt--;
                        owe(op_stack[stack_cnt], 1'b1, 1'b0, 1'b0);
                    end
                    if (stack_cnt < STACK_SLOTS) begin
                        op_stack[stack_cnt] = s;
                        stack_cnt++;
                    end
                    else begin
                        owe('0, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
            // Mark the final result of this transfer
            if (expected_postfix.size() > first) begin
                tail = expected_postfix.pop_back();
                tail.last = 1'b1;
                expected_postfix.push_back(tail);
            end
        endfunction

        function void check_result(postfix_res_t got);
            postfix_res_t want;
            if (expected_postfix.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual sym=%h has=%b last=%b done=%b ovf=%b",
                         $time, got.out_symbol, got.has_symbol, got.last, got.expr_done,
                         got.overflow);
                errors++;
            end
            else begin
                want = expected_postfix.pop_front();
                if (got.out_symbol !== want.out_symbol || got.has_symbol !== want.has_symbol ||
                    got.last !== want.last || got.expr_done !== want.expr_done ||
                    got.overflow !== want.overflow) begin
                    $display("%0t: result mismatch: expected sym=%h has=%b last=%b done=%b ovf=%b",
                             $time, want.out_symbol, want.has_symbol, want.last,
                             want.expr_done, want.overflow);
                    $display("%0t:                  actual   sym=%h has=%b last=%b done=%b ovf=%b",
                             $time, got.out_symbol, got.has_symbol, got.last, got.expr_done,
                             got.overflow);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_postfix.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    itp_in_if  sym_if ();
    itp_out_if res_if ();

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_if),
        .results (res_if)
    );

    postfix_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int hold_reqs;
    int hold_done;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: check each transfer, then decide ready for the next edge
    initial
    begin
        int hold_left;
        postfix_res_t got;
        hold_left = 0;
        hold_done = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                got.out_symbol = res_if.out_symbol;
                got.has_symbol = res_if.has_symbol;
                got.last       = res_if.last;
                got.expr_done  = res_if.expr_done;
                got.overflow   = res_if.overflow;
                sb.check_result(got);
            end
            if (hold_left == 0 && hold_done != hold_reqs) begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end
            else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [SYM_W-1:0] pick_operator();
        logic [SYM_W-1:0] s;
        case ($urandom_range(3))
            0:       s = CH_PLUS;
            1:       s = CH_MINUS;
            2:       s = CH_STAR;
            default: s = CH_SLASH;
        endcase
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] pick_operand();
        logic [SYM_W-1:0] s;
        do begin
            s = SYM_W'($urandom_range(255));
        end while (postfix_scoreboard::op_rank(s) != PREC_NONE);
        return s;
    endfunction

    // Offer one character and hold it until the block takes it
    task automatic send_symbol(input logic [SYM_W-1:0] s, input logic is_end);
        while ($urandom_range(99) < send_idle_pct) begin
            sym_if.valid <= 1'b0;
            @(posedge clk);
        end
        sym_if.valid  <= 1'b1;
        sym_if.symbol <= s;
        sym_if.is_end <= is_end;
        do begin
            @(posedge clk);
        end while (!sym_if.ready);
        sb.note_symbol(s, is_end);
        items_sent++;
    endtask

    // Operand, then alternating operator and operand, then an end marker
    task automatic send_expression(input int max_operands);
        int n;
        n = $urandom_range(max_operands, 1);
        for (int k = 0; k < n; k++) begin
            if (k > 0) begin
                send_symbol(pick_operator(), 1'b0);
            end
            send_symbol(pick_operand(), 1'b0);
        end
        send_symbol(SYM_W'($urandom_range(255)), 1'b1);
    endtask

    // Malformed runs: stray operators, bare ends, raw bytes
    task automatic send_noise();
        int n;
        int pick;
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_symbol(pick_operator(), 1'b0);
            end
            else if (pick < 50) begin
                send_symbol(SYM_W'($urandom_range(255)), 1'b1);
            end
            else begin
                send_symbol(SYM_W'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial
    begin
        items_sent = 0;
        hold_reqs = 0;
        send_idle_pct = 23;
        recv_idle_pct = 71;
        rst_n <= 1'b0;
        sym_if.valid  <= 1'b0;
        sym_if.symbol <= '0;
        sym_if.is_end <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-stack end, extreme operands, pops of both ranks, flush
        send_symbol(8'hFF, 1'b1);
        send_symbol(8'h00, 1'b0);
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(CH_STAR, 1'b0);
        send_symbol(8'h41, 1'b0);
        send_symbol(CH_MINUS, 1'b0);
        send_symbol(8'h42, 1'b0);
        send_symbol(CH_SLASH, 1'b0);
        send_symbol(8'h43, 1'b0);
        send_symbol(CH_STAR, 1'b1);
        send_symbol(8'h44, 1'b0);
        send_symbol(CH_STAR, 1'b0);
        send_symbol(CH_STAR, 1'b0);
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(CH_SLASH, 1'b0);
        send_symbol(CH_MINUS, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(CH_PLUS, 1'b0);
        send_symbol(8'h80, 1'b1);

        // Random expressions and noise under three idling regimes
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 71;
                recv_idle_pct = 23;
            end
            else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // Block the output while the input keeps coming
                hold_reqs++;
                send_expression(20);
                send_expression(20);
            end
            while (items_sent < ITEMS_PER_PHASE * (phase + 1)) begin
                if ($urandom_range(99) < 80) begin
                    send_expression(10);
                end
                else begin
                    send_noise();
                end
            end
        end
        sym_if.valid <= 1'b0;

        // Drain outstanding results, then allow for trailing output
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: infix_to_postfix_converter.f
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/itp_in_if.sv
hw/rtl/itp_out_if.sv
hw/rtl/itp_cell.sv
hw/rtl/itp_stack.sv
hw/rtl/infix_to_postfix_converter.sv
tb/sv/tb_top.sv
